// ----- design/starfield_projection_step_core_macros.svh -----
// Assertion helpers used by the starfield back end
`ifndef STARFIELD_PROJECTION_STEP_CORE_MACROS_SVH
`define STARFIELD_PROJECTION_STEP_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset
`define SFP_ASSERT_IMP(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("starfield assertion failed");

// Next-cycle implication, checked outside reset
`define SFP_ASSERT_NXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("starfield assertion failed");

`endif

// ----- design/sfp_pkg.sv -----
package sfp_pkg;

	// register indexes (byte address / 4)
	localparam logic [2:0] REG_CENTER_X = 3'd0;
	localparam logic [2:0] REG_CENTER_Y = 3'd1;
	localparam logic [2:0] REG_SCREEN_W = 3'd2;
	localparam logic [2:0] REG_SCREEN_H = 3'd3;
	localparam logic [2:0] REG_X_OFFSET = 3'd4;
	localparam logic [2:0] REG_DEPTH_STEP = 3'd5;
	localparam logic [2:0] REG_RNG_SEED = 3'd6;

	// reset values
	localparam logic [8:0] RST_CENTER_X = 9'd160;
	localparam logic [8:0] RST_CENTER_Y = 9'd120;
	localparam logic [9:0] RST_SCREEN_W = 10'd320;
	localparam logic [9:0] RST_SCREEN_H = 10'd240;
	localparam logic [7:0] RST_X_OFFSET = 8'd40;
	localparam logic [7:0] RST_DEPTH_STEP = 8'd2;
	localparam logic [31:0] RST_SEED = 32'd0;
	localparam logic [7:0] SPAWN_TOP = 8'd255;
	localparam logic [9:0] SCREEN_MAX = 10'd512;

	// one queued word between front and back
	typedef struct packed {
		logic [9:0] star_index;
		logic frame_start;
		logic in_range;
	} item_t;

	// live configuration seen by the back end
	typedef struct packed {
		logic [8:0] center_x;
		logic [8:0] center_y;
		logic [9:0] screen_width;
		logic [9:0] screen_height;
		logic [7:0] spawn_x_offset;
		logic [7:0] depth_step;
	} cfg_t;

endpackage

// ----- design/sfp_div.sv -----
module sfp_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [16:0] dividend,
	input  logic [7:0]  divisor,
	output logic        done,
	output logic [16:0] quot
);

	localparam int STEPS = 6;
	localparam logic [2:0] LAST = 3'(STEPS - 1);

	logic        busy_q;
	logic        done_q;
	logic [2:0]  cnt_q;
	logic [17:0] sh_q;
	logic [7:0]  rem_q;
	logic [7:0]  dvs_q;
	logic [17:0] sh_nx;
	logic [7:0]  rem_nx;

	// three restoring steps per cycle
	always_comb begin
		logic [8:0] r9;
		sh_nx = sh_q;
		rem_nx = rem_q;
		for (int i = 0; i < 3; i++) begin
			r9 = {rem_nx, sh_nx[17]};
			if (r9 >= {1'b0, dvs_q}) begin
				rem_nx = 8'(r9 - {1'b0, dvs_q});
				sh_nx = {sh_nx[16:0], 1'b1};
			end else begin
				rem_nx = r9[7:0];
				sh_nx = {sh_nx[16:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			sh_q <= {1'b0, dividend};
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			sh_q <= sh_nx;
			rem_q <= rem_nx;
		end
	end

	assign done = done_q;
	assign quot = sh_q[16:0];

endmodule

// ----- design/sfp_front.sv -----
module sfp_front #(
	parameter int NUM_STARS = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [9:0]         star_index,
	input  logic               frame_start,
	output logic               q_valid,
	output sfp_pkg::item_t     q_item,
	input  logic               q_pop
);

	sfp_pkg::item_t ent_q [2];
	logic           wp_q;
	logic           rp_q;
	logic [1:0]     cnt_q;
	logic           push;
	logic           in_range;

	// classify: star present in the table or not
	assign in_range = {7'd0, star_index} < 17'(NUM_STARS);
	assign in_stall = (cnt_q == 2'd2);
	assign push = in_valid && !in_stall;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (q_pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= '{star_index: star_index, frame_start: frame_start,
				in_range: in_range};
		end
	end

endmodule

// ----- design/sfp_back.sv -----
`include "starfield_projection_step_core_macros.svh"

module sfp_back #(
	parameter int NUM_STARS = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sfp_pkg::cfg_t      cfg,
	input  logic               seed_load,
	input  logic [31:0]        seed,
	input  logic               q_valid,
	input  sfp_pkg::item_t     q_item,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [8:0]         pixel_x,
	output logic [8:0]         pixel_y,
	output logic [15:0]        pixel_color,
	output logic               is_draw,
	output logic               last_pixel
);

	localparam int AW = (NUM_STARS > 1) ? $clog2(NUM_STARS) : 1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_LOAD, ST_RNG1, ST_RNG2, ST_START1, ST_WAIT1,
		ST_START2, ST_WAIT2, ST_EMIT
	} state_t;

	state_t st_q;

	logic [23:0] mem [NUM_STARS];
	logic [23:0] rd_q;
	logic        mem_we;
	logic [AW-1:0] mem_wa;
	logic [23:0] mem_wd;

	logic [AW:0]   clr_q;
	logic          clr_done;
	logic [AW-1:0] addr_q;
	logic [7:0]    x_q, y_q, dv_q, nx_q, spawn_q;
	logic [7:0]    rng_a_q, rng_b_q, rng_c_q, rng_n_q;
	logic [7:0]    ra_n, rb_n, rc_n, rn_n;
	logic          erase_v_q, draw_v_q;
	logic [8:0]    ex_q, ey_q, dx_q, dy_q;
	logic [15:0]   dcol_q;
	logic          out_valid_q, is_draw_q, last_q;
	logic [8:0]    ox_q, oy_q;
	logic [15:0]   ocol_q;

	logic          slot_free;
	logic          emit_go;
	logic          div_start;
	logic          div_done, div_done_y;
	logic [16:0]   qx, qy;
	logic [9:0]    diff_x, diff_y;
	logic [8:0]    mag_x, mag_y;
	logic [17:0]   px, py;
	logic [9:0]    w_cl, h_cl;
	logic          vis;
	logic [7:0]    nd;
	logic [7:0]    gray;
	logic [7:0]    d_rd;

	assign clr_done = (clr_q >= (AW+1)'(NUM_STARS));
	assign slot_free = !out_valid_q || !out_stall;
	assign emit_go = (st_q == ST_EMIT) && (erase_v_q || draw_v_q) && slot_free;
	assign d_rd = rd_q[7:0];

	// generator step
	always_comb begin
		rn_n = rng_n_q + 8'd1;
		ra_n = rng_a_q ^ rng_c_q ^ rn_n;
		rb_n = rng_b_q + ra_n;
		rc_n = (rng_c_q + {1'b0, rb_n[7:1]}) ^ ra_n;
	end

	// projection operands and results
	assign diff_x = {2'b00, x_q} - {1'b0, cfg.center_x};
	assign diff_y = {2'b00, y_q} - {1'b0, cfg.center_y};
	assign mag_x = diff_x[9] ? 9'(-diff_x) : diff_x[8:0];
	assign mag_y = diff_y[9] ? 9'(-diff_y) : diff_y[8:0];
	assign div_start = (st_q == ST_START1) || (st_q == ST_START2);
	assign px = (diff_x[9] ? -{1'b0, qx} : {1'b0, qx}) + {9'd0, cfg.center_x};
	assign py = (diff_y[9] ? -{1'b0, qy} : {1'b0, qy}) + {9'd0, cfg.center_y};
	assign w_cl = (cfg.screen_width > sfp_pkg::SCREEN_MAX) ? sfp_pkg::SCREEN_MAX
		: cfg.screen_width;
	assign h_cl = (cfg.screen_height > sfp_pkg::SCREEN_MAX) ? sfp_pkg::SCREEN_MAX
		: cfg.screen_height;
	assign vis = !px[17] && !py[17] && (px[16:0] < {7'd0, w_cl})
		&& (py[16:0] < {7'd0, h_cl});
	assign nd = (dv_q > cfg.depth_step) ? dv_q - cfg.depth_step : 8'd0;
	assign gray = 8'd255 - dv_q;

	sfp_div u_div_x (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend({mag_x, 8'h00}), .divisor(dv_q), .done(div_done), .quot(qx)
	);

	sfp_div u_div_y (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend({mag_y, 8'h00}), .divisor(dv_q), .done(div_done_y), .quot(qy)
	);

	// star table write port
	always_comb begin
		mem_we = 1'b0;
		mem_wa = addr_q;
		mem_wd = {x_q, y_q, nd};
		if (!clr_done) begin
			mem_we = 1'b1;
			mem_wa = clr_q[AW-1:0];
			mem_wd = '0;
		end else if (st_q == ST_RNG2) begin
			mem_we = 1'b1;
			mem_wd = {nx_q, rc_n, spawn_q};
		end else if (st_q == ST_WAIT1 && div_done && nd <= 8'd1) begin
			mem_we = 1'b1;
		end else if (st_q == ST_WAIT2 && div_done) begin
			mem_we = 1'b1;
			mem_wd = {x_q, y_q, vis ? dv_q : 8'd0};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rd_q <= mem[AW'(q_item.star_index)];
	end

	assign q_pop = (st_q == ST_IDLE) && clr_done && q_valid;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			clr_q <= '0;
			spawn_q <= sfp_pkg::SPAWN_TOP;
			rng_a_q <= sfp_pkg::RST_SEED[7:0];
			rng_b_q <= sfp_pkg::RST_SEED[15:8];
			rng_c_q <= sfp_pkg::RST_SEED[23:16];
			rng_n_q <= sfp_pkg::RST_SEED[31:24];
			erase_v_q <= 1'b0;
			draw_v_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!clr_done) clr_q <= clr_q + 1'b1;
			if (seed_load) begin
				rng_a_q <= seed[7:0];
				rng_b_q <= seed[15:8];
				rng_c_q <= seed[23:16];
				rng_n_q <= seed[31:24];
			end
			// drop a taken word unless a new one replaces it
			if (out_valid_q && !out_stall && !emit_go) out_valid_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (q_pop) begin
						addr_q <= AW'(q_item.star_index);
						if (q_item.frame_start) spawn_q <= sfp_pkg::SPAWN_TOP;
						if (q_item.in_range) st_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					x_q <= rd_q[23:16];
					y_q <= rd_q[15:8];
					dv_q <= d_rd;
					st_q <= (d_rd <= 8'd1) ? ST_RNG1 : ST_START1;
				end
				ST_RNG1: begin
					{rng_a_q, rng_b_q, rng_c_q, rng_n_q} <= {ra_n, rb_n, rc_n, rn_n};
					nx_q <= cfg.spawn_x_offset + rc_n;
					st_q <= ST_RNG2;
				end
				ST_RNG2: begin
					{rng_a_q, rng_b_q, rng_c_q, rng_n_q} <= {ra_n, rb_n, rc_n, rn_n};
					spawn_q <= spawn_q - 8'd1;
					st_q <= ST_IDLE;
				end
				ST_START1: st_q <= ST_WAIT1;
				ST_WAIT1: begin
					if (div_done) begin
						erase_v_q <= vis;
						ex_q <= px[8:0];
						ey_q <= py[8:0];
						dv_q <= nd;
						draw_v_q <= 1'b0;
						st_q <= (nd > 8'd1) ? ST_START2 : ST_EMIT;
					end
				end
				ST_START2: st_q <= ST_WAIT2;
				ST_WAIT2: begin
					if (div_done) begin
						draw_v_q <= vis;
						dx_q <= px[8:0];
						dy_q <= py[8:0];
						dcol_q <= {gray[7:3], gray[7:2], gray[7:3]};
						st_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (erase_v_q) begin
						if (slot_free) begin
							out_valid_q <= 1'b1;
							ox_q <= ex_q;
							oy_q <= ey_q;
							ocol_q <= '0;
							is_draw_q <= 1'b0;
							last_q <= !draw_v_q;
							erase_v_q <= 1'b0;
						end
					end else if (draw_v_q) begin
						if (slot_free) begin
							out_valid_q <= 1'b1;
							ox_q <= dx_q;
							oy_q <= dy_q;
							ocol_q <= dcol_q;
							is_draw_q <= 1'b1;
							last_q <= 1'b1;
							draw_v_q <= 1'b0;
						end
					end else begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_x = ox_q;
	assign pixel_y = oy_q;
	assign pixel_color = ocol_q;
	assign is_draw = is_draw_q;
	assign last_pixel = last_q;

	`SFP_ASSERT_IMP(a_clear_idle, !clr_done, st_q == ST_IDLE)
	`SFP_ASSERT_IMP(a_erase_black, out_valid_q && !is_draw_q, ocol_q == 16'd0)
	`SFP_ASSERT_IMP(a_div_pair, div_done, div_done_y && (st_q == ST_WAIT1 || st_q == ST_WAIT2))
	`SFP_ASSERT_NXT(a_start_wait, div_start, st_q == ST_WAIT1 || st_q == ST_WAIT2)

endmodule

// ----- design/starfield_projection_step_core.sv -----
// Starfield step core: one star word in, up to two pixel words out.
// A star at depth 1 or 0 respawns via LOAD, RNG1, RNG2; others go through one
// or two rounds of the paired 3-bit-per-cycle dividers (erase, then draw) and
// EMIT. An index beyond the table is popped and dropped. One star word is
// worked at a time; a two-entry queue in front holds the words that wait.
// Reset: registers to defaults, then a pass over the table clears depths;
// no star word leaves the queue until it ends. Config writes are taken throughout.
module starfield_projection_step_core #(
	parameter int NUM_STARS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [9:0]  star_index,
	input  logic        frame_start,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [8:0]  pixel_x,
	output logic [8:0]  pixel_y,
	output logic [15:0] pixel_color,
	output logic        is_draw,
	output logic        last_pixel
);

	sfp_pkg::cfg_t  cfg_q;
	logic [31:0]    seed_q;
	logic           wr;
	logic [2:0]     reg_idx;
	logic           q_valid;
	logic           q_pop;
	sfp_pkg::item_t q_item;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x <= sfp_pkg::RST_CENTER_X;
			cfg_q.center_y <= sfp_pkg::RST_CENTER_Y;
			cfg_q.screen_width <= sfp_pkg::RST_SCREEN_W;
			cfg_q.screen_height <= sfp_pkg::RST_SCREEN_H;
			cfg_q.spawn_x_offset <= sfp_pkg::RST_X_OFFSET;
			cfg_q.depth_step <= sfp_pkg::RST_DEPTH_STEP;
			seed_q <= sfp_pkg::RST_SEED;
		end else if (wr) begin
			case (reg_idx)
				sfp_pkg::REG_CENTER_X: cfg_q.center_x <= pwdata[8:0];
				sfp_pkg::REG_CENTER_Y: cfg_q.center_y <= pwdata[8:0];
				sfp_pkg::REG_SCREEN_W: cfg_q.screen_width <= pwdata[9:0];
				sfp_pkg::REG_SCREEN_H: cfg_q.screen_height <= pwdata[9:0];
				sfp_pkg::REG_X_OFFSET: cfg_q.spawn_x_offset <= pwdata[7:0];
				sfp_pkg::REG_DEPTH_STEP: cfg_q.depth_step <= pwdata[7:0];
				sfp_pkg::REG_RNG_SEED: seed_q <= pwdata;
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		case (reg_idx)
			sfp_pkg::REG_CENTER_X: prdata = {23'd0, cfg_q.center_x};
			sfp_pkg::REG_CENTER_Y: prdata = {23'd0, cfg_q.center_y};
			sfp_pkg::REG_SCREEN_W: prdata = {22'd0, cfg_q.screen_width};
			sfp_pkg::REG_SCREEN_H: prdata = {22'd0, cfg_q.screen_height};
			sfp_pkg::REG_X_OFFSET: prdata = {24'd0, cfg_q.spawn_x_offset};
			sfp_pkg::REG_DEPTH_STEP: prdata = {24'd0, cfg_q.depth_step};
			sfp_pkg::REG_RNG_SEED: prdata = seed_q;
			default: prdata = '0;
		endcase
	end

	sfp_front #(.NUM_STARS(NUM_STARS)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.star_index(star_index), .frame_start(frame_start),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
	);

	sfp_back #(.NUM_STARS(NUM_STARS)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.seed_load(wr && reg_idx == sfp_pkg::REG_RNG_SEED), .seed(pwdata),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
		.out_valid(out_valid), .out_stall(out_stall),
		.pixel_x(pixel_x), .pixel_y(pixel_y), .pixel_color(pixel_color),
		.is_draw(is_draw), .last_pixel(last_pixel)
	);

endmodule
